// ===== rtl/grid_maze_dfs_solver_defines.svh =====
// Assertion macros for the grid maze solver checker.
// Depends on nothing; the including scope supplies clock and reset.
`ifndef GRID_MAZE_DFS_SOLVER_DEFINES_SVH
`define GRID_MAZE_DFS_SOLVER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GMDS_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gmds same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define GMDS_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gmds next-cycle check failed");

`endif

// ===== rtl/gmds_pkg.sv =====
// Shared types and codes for the grid maze solver.
// Depends on nothing; used by the step unit, the top level and the checker.
package gmds_pkg;

   // Width of coordinate and bound arithmetic (covers 256 plus one)
   localparam int COORD_W = 9;

   // Request kinds
   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_SOLVE = 2'd2
   } req_kind_type;

   // Cell states held in the grid
   localparam logic [1:0] CELL_OPEN = 2'd0;
   localparam logic [1:0] CELL_WALL = 2'd1;
   localparam logic [1:0] CELL_MARK = 2'd2;

   // Register indexes
   localparam logic [1:0] REG_ROW_COUNT = 2'd0;
   localparam logic [1:0] REG_COL_COUNT = 2'd1;
   localparam logic [1:0] REG_START_ROW = 2'd2;
   localparam logic [1:0] REG_END_ROW   = 2'd3;

   // Neighbor order: down, up, right, left
   typedef enum logic [1:0] {
      DIR_DOWN  = 2'd0,
      DIR_UP    = 2'd1,
      DIR_RIGHT = 2'd2,
      DIR_LEFT  = 2'd3
   } dir_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_CLEAR,
      ST_START,
      ST_POP,
      ST_CHECK,
      ST_NB_ADDR,
      ST_NB_EVAL,
      ST_REPLY
   } state_type;

   // Neighbor produced by the step unit
   typedef struct packed {
      logic               in_grid;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } nbr_type;

endpackage

// ===== rtl/gmds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module gmds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gmds_step_unit.sv =====
// Shared neighbor step unit: one increment or decrement and one bound compare.
// Depends on gmds_pkg.
module gmds_step_unit (
   input  logic [gmds_pkg::COORD_W-1:0] cur_row,
   input  logic [gmds_pkg::COORD_W-1:0] cur_col,
   input  gmds_pkg::dir_type            dir,
   input  logic [gmds_pkg::COORD_W-1:0] row_lim,
   input  logic [gmds_pkg::COORD_W-1:0] col_lim,
   output gmds_pkg::nbr_type            nbr
);
   import gmds_pkg::*;

   logic               on_row;
   logic               plus;
   logic [COORD_W-1:0] coord;
   logic [COORD_W-1:0] lim;
   logic [COORD_W-1:0] moved;

   // Decode direction into axis and sign
   always_comb begin
      unique case (dir)
         DIR_DOWN: begin
            on_row = 1'b1;
            plus   = 1'b1;
         end
         DIR_UP: begin
            on_row = 1'b1;
            plus   = 1'b0;
         end
         DIR_RIGHT: begin
            on_row = 1'b0;
            plus   = 1'b1;
         end
         default: begin
            on_row = 1'b0;
            plus   = 1'b0;
         end
      endcase
   end

   // Step along the chosen axis and check the grid bound
   always_comb begin
      coord       = on_row ? cur_row : cur_col;
      lim         = on_row ? row_lim : col_lim;
      moved       = plus ? coord + COORD_W'(1) : coord - COORD_W'(1);
      nbr.in_grid = plus ? (moved < lim) : (coord != '0);
      nbr.row     = on_row ? moved : cur_row;
      nbr.col     = on_row ? cur_col : moved;
   end

endmodule

// ===== rtl/grid_maze_dfs_solver.sv =====
// Grid maze solver top level: channels, register file, search sequencer.
// Depends on gmds_pkg, gmds_ram and gmds_step_unit.
//
// Requests arrive on the req_ channel (valid/stall) and each gets exactly one
// reply on the rsp_ channel. A write stores one cell (1 wall, 0 open), a read
// returns the cell state (0 open, 1 wall, 2 marked), a solve runs a
// depth-first search from (start_row, column 0) to (end_row, last column) and
// returns path_found. The csr_ port writes row_count, col_count, start_row and
// end_row; the user must write them only while the block is idle, which the block itself does not enforce.
// A write goes from idle straight to the reply state, a read via the read state.
// A solve first sweeps the visited memory, one entry per cycle over all
// 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) entries (1024 at the defaults), then
// takes each popped cell through the pop and check states and each neighbor
// through the shared step unit's address state and, if inside, the eval state.
// One request is worked on at a time; req_stall is high from the cycle after
// a transfer until the reply is handed to the output register, which can
// hold a reply while the next request is taken.
// Reset (synchronous, active high) clears the sequencer, the reply register
// and the registers to 8, 8, 1, 1; grid contents stay undefined until written.
// While rsp_stall is high the reply holds in the output register.
module grid_maze_dfs_solver #(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 32
) (
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_write,
   input  logic [1:0] csr_index,
   input  logic [5:0] csr_data,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [4:0] req_cell_row,
   input  logic [4:0] req_cell_col,
   input  logic       req_cell_wall,
   // reply channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_reply_kind,
   output logic [1:0] rsp_cell_state,
   output logic       rsp_path_found
);
   import gmds_pkg::*;

   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CW    = $clog2(MAX_COLS);
   localparam int AW    = RW + CW;
   localparam int DEPTH = 1 << AW;

   // configuration registers
   logic [5:0] row_count_ff, row_count_in;
   logic [5:0] col_count_ff, col_count_in;
   logic [4:0] start_row_ff, start_row_in;
   logic [4:0] end_row_ff,   end_row_in;

   // sequencer state
   state_type     state_ff, state_in;
   logic [1:0]    kind_ff, kind_in;
   logic [1:0]    res_state_ff, res_state_in;
   logic          res_found_ff, res_found_in;
   logic          rd_inside_ff, rd_inside_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [AW:0]   depth_ff, depth_in;
   logic [AW-1:0] cur_ff, cur_in;
   dir_type       dir_ff, dir_in;
   logic [AW-1:0] nb_addr_ff, nb_addr_in;

   // reply register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_kind_ff, rsp_kind_in;
   logic [1:0] rsp_state_ff, rsp_state_in;
   logic       rsp_found_ff, rsp_found_in;

   // memory ports
   logic          grid_we;
   logic [AW-1:0] grid_waddr, grid_raddr;
   logic [1:0]    grid_wdata, grid_rdata;
   logic          vis_we;
   logic [AW-1:0] vis_waddr, vis_raddr;
   logic          vis_wdata, vis_rdata;
   logic          stk_we;
   logic [AW-1:0] stk_waddr, stk_raddr;
   logic [AW-1:0] stk_wdata, stk_rdata;

   // derived values
   logic               req_accept;
   logic               reply_free;
   logic [COORD_W-1:0] req_row_ext, req_col_ext;
   logic               req_inside;
   logic [AW-1:0]      req_addr;
   logic [COORD_W-1:0] rows_lim, cols_lim;
   logic [COORD_W-1:0] start_ext;
   logic               start_ok;
   logic [AW-1:0]      start_addr;
   logic               at_target;
   logic [AW:0]        depth_dec;
   nbr_type            nbr;
   logic [AW-1:0]      nbr_addr;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign reply_free = !rsp_valid_ff || !rsp_stall;

   // request address and range check
   assign req_row_ext = COORD_W'(req_cell_row);
   assign req_col_ext = COORD_W'(req_cell_col);
   assign req_inside  = (req_row_ext < COORD_W'(MAX_ROWS)) &&
                        (req_col_ext < COORD_W'(MAX_COLS));
   assign req_addr    = {req_row_ext[RW-1:0], req_col_ext[CW-1:0]};

   // grid bounds saturated at the built size
   assign rows_lim = (COORD_W'(row_count_ff) > COORD_W'(MAX_ROWS)) ?
                     COORD_W'(MAX_ROWS) : COORD_W'(row_count_ff);
   assign cols_lim = (COORD_W'(col_count_ff) > COORD_W'(MAX_COLS)) ?
                     COORD_W'(MAX_COLS) : COORD_W'(col_count_ff);

   // entry cell
   assign start_ext  = COORD_W'(start_row_ff);
   assign start_ok   = (rows_lim != '0) && (cols_lim != '0) && (start_ext < rows_lim);
   assign start_addr = {start_ext[RW-1:0], {CW{1'b0}}};

   // exit check on the cell just popped
   assign at_target = (COORD_W'(stk_rdata[AW-1:CW]) == COORD_W'(end_row_ff)) &&
                      (COORD_W'(stk_rdata[CW-1:0]) == cols_lim - COORD_W'(1));

   assign depth_dec = depth_ff - 1'b1;

   // shared neighbor step unit
   gmds_step_unit u_step (
      .cur_row (COORD_W'(cur_ff[AW-1:CW])),
      .cur_col (COORD_W'(cur_ff[CW-1:0])),
      .dir     (dir_ff),
      .row_lim (rows_lim),
      .col_lim (cols_lim),
      .nbr     (nbr)
   );

   assign nbr_addr = {nbr.row[RW-1:0], nbr.col[CW-1:0]};

   // memories
   gmds_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_grid_ram (
      .clock   (clock),
      .wr_en   (grid_we),
      .wr_addr (grid_waddr),
      .wr_data (grid_wdata),
      .rd_addr (grid_raddr),
      .rd_data (grid_rdata)
   );

   gmds_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_visit_ram (
      .clock   (clock),
      .wr_en   (vis_we),
      .wr_addr (vis_waddr),
      .wr_data (vis_wdata),
      .rd_addr (vis_raddr),
      .rd_data (vis_rdata)
   );

   gmds_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   // configuration writes
   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      start_row_in = start_row_ff;
      end_row_in   = end_row_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_ROW_COUNT: row_count_in = csr_data;
            REG_COL_COUNT: col_count_in = csr_data;
            REG_START_ROW: start_row_in = csr_data[4:0];
            REG_END_ROW:   end_row_in   = csr_data[4:0];
            default:       row_count_in = row_count_ff;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_type == REQ_SOLVE) begin
                  state_in = ST_CLEAR;
               end else if (req_type == REQ_READ) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_REPLY;
               end
            end
         end
         ST_READ:  state_in = ST_REPLY;
         ST_CLEAR: begin
            if (&clr_addr_ff) begin
               state_in = ST_START;
            end
         end
         ST_START: state_in = start_ok ? ST_POP : ST_REPLY;
         ST_POP:   state_in = (depth_ff == '0) ? ST_REPLY : ST_CHECK;
         ST_CHECK: state_in = at_target ? ST_REPLY : ST_NB_ADDR;
         ST_NB_ADDR: begin
            if (nbr.in_grid) begin
               state_in = ST_NB_EVAL;
            end else if (dir_ff == DIR_LEFT) begin
               state_in = ST_POP;
            end
         end
         ST_NB_EVAL: state_in = (dir_ff == DIR_LEFT) ? ST_POP : ST_NB_ADDR;
         ST_REPLY: begin
            if (reply_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      kind_in      = kind_ff;
      res_state_in = res_state_ff;
      res_found_in = res_found_ff;
      rd_inside_in = rd_inside_ff;
      clr_addr_in  = clr_addr_ff;
      depth_in     = depth_ff;
      cur_in       = cur_ff;
      dir_in       = dir_ff;
      nb_addr_in   = nb_addr_ff;

      grid_we    = 1'b0;
      grid_waddr = nb_addr_ff;
      grid_wdata = CELL_MARK;
      grid_raddr = (state_ff == ST_IDLE) ? req_addr : nbr_addr;
      vis_we     = 1'b0;
      vis_waddr  = nb_addr_ff;
      vis_wdata  = 1'b1;
      vis_raddr  = nbr_addr;
      stk_we     = 1'b0;
      stk_waddr  = depth_ff[AW-1:0];
      stk_wdata  = nb_addr_ff;
      stk_raddr  = depth_dec[AW-1:0];

      // drop the reply once it is taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_state_in = rsp_state_ff;
      rsp_found_in = rsp_found_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               kind_in      = req_type;
               res_state_in = CELL_OPEN;
               res_found_in = 1'b0;
               rd_inside_in = req_inside;
               clr_addr_in  = '0;
               if ((req_type == REQ_WRITE) && req_inside) begin
                  grid_we    = 1'b1;
                  grid_waddr = req_addr;
                  grid_wdata = req_cell_wall ? CELL_WALL : CELL_OPEN;
               end
            end
         end
         ST_READ: begin
            res_state_in = rd_inside_ff ? grid_rdata : CELL_OPEN;
         end
         ST_CLEAR: begin
            vis_we      = 1'b1;
            vis_waddr   = clr_addr_ff;
            vis_wdata   = 1'b0;
            clr_addr_in = clr_addr_ff + 1'b1;
            depth_in    = '0;
         end
         ST_START: begin
            if (start_ok) begin
               vis_we    = 1'b1;
               vis_waddr = start_addr;
               stk_we    = 1'b1;
               stk_waddr = '0;
               stk_wdata = start_addr;
               depth_in  = (AW+1)'(1);
            end
         end
         ST_POP: begin
            if (depth_ff != '0) begin
               depth_in = depth_dec;
            end
         end
         ST_CHECK: begin
            cur_in = stk_rdata;
            dir_in = DIR_DOWN;
            if (at_target) begin
               res_found_in = 1'b1;
            end
         end
         ST_NB_ADDR: begin
            nb_addr_in = nbr_addr;
            if (!nbr.in_grid) begin
               dir_in = dir_type'(dir_ff + 2'd1);
            end
         end
         ST_NB_EVAL: begin
            // mark and push an open, unvisited neighbor
            if ((grid_rdata == CELL_OPEN) && !vis_rdata) begin
               grid_we  = 1'b1;
               vis_we   = 1'b1;
               stk_we   = 1'b1;
               depth_in = depth_ff + 1'b1;
            end
            dir_in = dir_type'(dir_ff + 2'd1);
         end
         ST_REPLY: begin
            if (reply_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_state_in = (kind_ff == REQ_READ) ? res_state_ff : CELL_OPEN;
               rsp_found_in = (kind_ff == REQ_SOLVE) && res_found_ff;
            end
         end
         default: begin
            depth_in = depth_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         row_count_ff <= 6'd8;
         col_count_ff <= 6'd8;
         start_row_ff <= 5'd1;
         end_row_ff   <= 5'd1;
         depth_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         start_row_ff <= start_row_in;
         end_row_ff   <= end_row_in;
         depth_ff     <= depth_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      res_state_ff <= res_state_in;
      res_found_ff <= res_found_in;
      rd_inside_ff <= rd_inside_in;
      clr_addr_ff  <= clr_addr_in;
      cur_ff       <= cur_in;
      dir_ff       <= dir_in;
      nb_addr_ff   <= nb_addr_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_state_ff <= rsp_state_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reply_kind = rsp_kind_ff;
   assign rsp_cell_state = rsp_state_ff;
   assign rsp_path_found = rsp_found_ff;

endmodule

// ===== rtl/gmds_checker.sv =====
// Port-level checker for the grid maze solver, bound to the top level.
// Depends on gmds_pkg and grid_maze_dfs_solver_defines.svh.
`include "grid_maze_dfs_solver_defines.svh"

module gmds_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [1:0] req_type,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_reply_kind,
   input logic [1:0] rsp_cell_state,
   input logic       rsp_path_found
);
   import gmds_pkg::*;

   // hold a stalled reply
   `GMDS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
   // one request at a time: busy right after a transfer of any kind
   `GMDS_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)
   // only a solve reply carries a path flag
   `GMDS_ASSERT_SAME(a_found_solve_only, rsp_valid && (rsp_reply_kind != REQ_SOLVE), !rsp_path_found)
   // only a read reply carries a cell state
   `GMDS_ASSERT_SAME(a_state_read_only, rsp_valid && (rsp_reply_kind != REQ_READ), rsp_cell_state == CELL_OPEN)

endmodule

bind grid_maze_dfs_solver gmds_checker u_gmds_checker (.*);
